// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top level of the window cover finder.
// Define NO_ASSERTIONS to compile the checks out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hdl/mwc_pkg.sv =====
// Shared types and fixed constants of the minimum window cover finder.
// No dependencies; every other RTL file refers to it by scoped names.
package mwc_pkg;

    localparam int unsigned SYM_W   = 8;
    localparam int unsigned START_W = 12;
    localparam int unsigned LEN_W   = 13;

    typedef struct packed {
        logic             mode;
        logic [SYM_W-1:0] symbol;
        logic             last;
    } t_in_word;

    typedef struct packed {
        logic               found;
        logic [START_W-1:0] start_res;
        logic [LEN_W-1:0]   length;
        logic               overflow;
    } t_out_word;

    // Result handed from the sequencer to the output register.
    typedef struct packed {
        logic      load;
        t_out_word word;
    } t_res;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } t_need_ctl;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_text_ctl;

    localparam logic MODE_PATTERN = 1'b0;
    localparam logic MODE_TEXT    = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_SHR_T,
        S_SHR_N,
        S_SHR_W,
        S_RES
    } t_state;

endpackage

// ===== hdl/mwc_need_ram.sv =====
// Per-symbol need count table: synchronous RAM with registered read data
// plus a valid bit per entry so a whole job clears at once. Uses mwc_pkg.
module mwc_need_ram #(
    parameter int unsigned ALPHABET = 256,
    parameter int unsigned CW       = 14
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mwc_pkg::t_need_ctl          i_ctl,
    input  logic [$clog2(ALPHABET)-1:0] i_rd_addr,
    input  logic [$clog2(ALPHABET)-1:0] i_wr_addr,
    input  logic [CW-1:0]               i_wr_data,
    output logic [CW-1:0]               o_rd_data
);
    logic [CW-1:0]       r_mem [ALPHABET];
    logic [ALPHABET-1:0] r_vld;
    logic [CW-1:0]       r_rd_data;
    logic                r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.clr) begin
                r_vld <= '0;
            end else if (i_ctl.wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    // An entry not written since the last clear reads as zero.
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== hdl/mwc_text_ram.sv =====
// Text symbol store: single-port-write, single-read synchronous RAM with
// registered read data and no reset. Uses mwc_pkg for its control type.
module mwc_text_ram #(
    parameter int unsigned TEXT_DEPTH = 4096,
    parameter int unsigned DW         = 8
) (
    input  logic                          i_clk,
    input  mwc_pkg::t_text_ctl            i_ctl,
    input  logic [$clog2(TEXT_DEPTH)-1:0] i_rd_addr,
    input  logic [$clog2(TEXT_DEPTH)-1:0] i_wr_addr,
    input  logic [DW-1:0]                 i_wr_data,
    output logic [DW-1:0]                 o_rd_data
);
    logic [DW-1:0] r_mem [TEXT_DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/mwc_seq.sv =====
// Sequencer of the window cover finder: job counters, best window record,
// need RAM read-modify-write steps and text RAM accesses. Uses mwc_pkg.
module mwc_seq #(
    parameter int unsigned TEXT_DEPTH = 4096,
    parameter int unsigned ALPHABET   = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  mwc_pkg::t_in_word             i_in_word,
    input  logic                          i_slot_free,
    output mwc_pkg::t_res                 o_res,
    output mwc_pkg::t_need_ctl            o_need_ctl,
    output logic [$clog2(ALPHABET)-1:0]   o_need_rd_addr,
    output logic [$clog2(ALPHABET)-1:0]   o_need_wr_addr,
    output logic [$clog2(TEXT_DEPTH)+1:0] o_need_wr_data,
    input  logic [$clog2(TEXT_DEPTH)+1:0] i_need_rd_data,
    output mwc_pkg::t_text_ctl            o_text_ctl,
    output logic [$clog2(TEXT_DEPTH)-1:0] o_text_rd_addr,
    output logic [$clog2(TEXT_DEPTH)-1:0] o_text_wr_addr,
    output logic [$clog2(ALPHABET)-1:0]   o_text_wr_data,
    input  logic [$clog2(ALPHABET)-1:0]   i_text_rd_data
);
    localparam int unsigned AW = $clog2(ALPHABET);
    localparam int unsigned TW = $clog2(TEXT_DEPTH);
    localparam int unsigned LW = $clog2(TEXT_DEPTH + 1);
    localparam int unsigned CW = $clog2(TEXT_DEPTH) + 2;
    localparam int unsigned NSYM = 1 << mwc_pkg::SYM_W;
    localparam logic [LW-1:0] DEPTH_L = LW'(TEXT_DEPTH);

    mwc_pkg::t_state r_state, n_state;

    logic          r_mode, n_mode;
    logic [AW-1:0] r_sym, n_sym;
    logic          r_last, n_last;
    logic [AW-1:0] r_out_sym, n_out_sym;
    logic [LW-1:0] r_text_len, n_text_len;
    logic [LW-1:0] r_pat_len, n_pat_len;
    logic [LW-1:0] r_unmet, n_unmet;
    logic [LW-1:0] r_left, n_left;
    logic [TW-1:0] r_best_start, n_best_start;
    logic [LW-1:0] r_best_len, n_best_len;
    logic          r_ovf, n_ovf;

    logic          w_accept;
    logic [AW-1:0] w_mod_tab [NSYM];
    logic [AW-1:0] w_sym_mod;
    logic          w_pat_ok;
    logic          w_txt_ok;
    logic [CW-1:0] w_need_dec;
    logic [CW-1:0] w_need_inc;
    logic [LW-1:0] w_span;
    logic [31:0]   w_start32;
    logic [31:0]   w_len32;
    logic          w_found;

    // Symbol reduction modulo the alphabet size as a constant table.
    for (genvar k = 0; k < NSYM; k++) begin : g_mod
        assign w_mod_tab[k] = AW'(k % ALPHABET);
    end

    assign w_sym_mod  = w_mod_tab[i_in_word.symbol];
    assign w_accept   = i_in_valid && (r_state == mwc_pkg::S_IDLE);
    assign w_pat_ok   = (r_text_len == '0) && (r_pat_len < DEPTH_L);
    assign w_txt_ok   = r_text_len < DEPTH_L;
    assign w_need_dec = i_need_rd_data - CW'(1);
    assign w_need_inc = i_need_rd_data + CW'(1);
    assign w_span     = r_text_len - r_left;

    // Datapath next values.
    always_comb begin
        n_mode       = r_mode;
        n_sym        = r_sym;
        n_last       = r_last;
        n_out_sym    = r_out_sym;
        n_text_len   = r_text_len;
        n_pat_len    = r_pat_len;
        n_unmet      = r_unmet;
        n_left       = r_left;
        n_best_start = r_best_start;
        n_best_len   = r_best_len;
        n_ovf        = r_ovf;
        case (r_state)
            mwc_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_mode = i_in_word.mode;
                    n_sym  = w_sym_mod;
                    n_last = i_in_word.last;
                end
            end
            mwc_pkg::S_UPD: begin
                if (r_mode == mwc_pkg::MODE_PATTERN) begin
                    if (w_pat_ok) begin
                        n_pat_len = r_pat_len + LW'(1);
                        n_unmet   = r_unmet + LW'(1);
                    end else if (r_text_len == '0) begin
                        n_ovf = 1'b1;
                    end
                end else if (w_txt_ok) begin
                    n_text_len = r_text_len + LW'(1);
                    if (!w_need_dec[CW-1] && (r_unmet != '0)) begin
                        n_unmet = r_unmet - LW'(1);
                    end
                end else begin
                    n_ovf = 1'b1;
                end
            end
            mwc_pkg::S_SHR_T: begin
                if ((r_best_len == '0) || (w_span < r_best_len)) begin
                    n_best_len   = w_span;
                    n_best_start = r_left[TW-1:0];
                end
            end
            mwc_pkg::S_SHR_N: begin
                n_out_sym = i_text_rd_data;
            end
            mwc_pkg::S_SHR_W: begin
                n_left = r_left + LW'(1);
                if (!w_need_inc[CW-1] && (w_need_inc != '0)) begin
                    n_unmet = r_unmet + LW'(1);
                end
            end
            mwc_pkg::S_RES: begin
                if (i_slot_free) begin
                    n_text_len   = '0;
                    n_pat_len    = '0;
                    n_unmet      = '0;
                    n_left       = '0;
                    n_best_start = '0;
                    n_best_len   = '0;
                    n_ovf        = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mwc_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = mwc_pkg::S_UPD;
                end
            end
            mwc_pkg::S_UPD: begin
                if ((r_mode == mwc_pkg::MODE_TEXT) && w_txt_ok && (r_pat_len != '0)
                        && (n_unmet == '0) && (r_left < n_text_len)) begin
                    n_state = mwc_pkg::S_SHR_T;
                end else if ((r_mode == mwc_pkg::MODE_TEXT) && r_last) begin
                    n_state = mwc_pkg::S_RES;
                end else begin
                    n_state = mwc_pkg::S_IDLE;
                end
            end
            mwc_pkg::S_SHR_T: begin
                n_state = mwc_pkg::S_SHR_N;
            end
            mwc_pkg::S_SHR_N: begin
                n_state = mwc_pkg::S_SHR_W;
            end
            mwc_pkg::S_SHR_W: begin
                if ((n_unmet == '0) && (n_left < r_text_len)) begin
                    n_state = mwc_pkg::S_SHR_T;
                end else if (r_last) begin
                    n_state = mwc_pkg::S_RES;
                end else begin
                    n_state = mwc_pkg::S_IDLE;
                end
            end
            mwc_pkg::S_RES: begin
                if (i_slot_free) begin
                    n_state = mwc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mwc_pkg::S_IDLE;
            end
        endcase
    end

    assign w_found   = r_best_len != '0;
    assign w_start32 = 32'(r_best_start);
    assign w_len32   = 32'(r_best_len);

    // Outputs: handshake, memory controls and result.
    always_comb begin
        o_in_stall       = (r_state != mwc_pkg::S_IDLE);
        o_need_ctl       = '0;
        o_need_rd_addr   = w_sym_mod;
        o_need_wr_addr   = r_sym;
        o_need_wr_data   = w_need_inc;
        o_text_ctl       = '0;
        o_text_rd_addr   = r_left[TW-1:0];
        o_text_wr_addr   = r_text_len[TW-1:0];
        o_text_wr_data   = w_sym_mod;
        o_res.load       = 1'b0;
        o_res.word.found     = w_found;
        o_res.word.start_res = w_found ? w_start32[mwc_pkg::START_W-1:0] : '0;
        o_res.word.length    = w_len32[mwc_pkg::LEN_W-1:0];
        o_res.word.overflow  = r_ovf;
        case (r_state)
            mwc_pkg::S_IDLE: begin
                o_need_ctl.rd_en = w_accept;
                o_text_ctl.wr_en = w_accept && (i_in_word.mode == mwc_pkg::MODE_TEXT)
                                   && w_txt_ok;
            end
            mwc_pkg::S_UPD: begin
                if (r_mode == mwc_pkg::MODE_PATTERN) begin
                    o_need_ctl.wr_en = w_pat_ok;
                end else begin
                    o_need_ctl.wr_en = w_txt_ok;
                    o_need_wr_data   = w_need_dec;
                end
            end
            mwc_pkg::S_SHR_T: begin
                o_text_ctl.rd_en = 1'b1;
            end
            mwc_pkg::S_SHR_N: begin
                o_need_ctl.rd_en = 1'b1;
                o_need_rd_addr   = i_text_rd_data;
            end
            mwc_pkg::S_SHR_W: begin
                o_need_ctl.wr_en = 1'b1;
                o_need_wr_addr   = r_out_sym;
            end
            mwc_pkg::S_RES: begin
                o_res.load     = i_slot_free;
                o_need_ctl.clr = i_slot_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mwc_pkg::S_IDLE;
            r_text_len   <= '0;
            r_pat_len    <= '0;
            r_unmet      <= '0;
            r_left       <= '0;
            r_best_start <= '0;
            r_best_len   <= '0;
            r_ovf        <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_text_len   <= n_text_len;
            r_pat_len    <= n_pat_len;
            r_unmet      <= n_unmet;
            r_left       <= n_left;
            r_best_start <= n_best_start;
            r_best_len   <= n_best_len;
            r_ovf        <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_sym     <= n_sym;
        r_last    <= n_last;
        r_out_sym <= n_out_sym;
    end

endmodule

// ===== hdl/min_window_cover_finder.sv =====
// Minimum window cover finder, top level.
// Input channel (i_in_valid / o_in_stall / i_in_word): a job sends its
// pattern words (mode 0) and then its text words (mode 1); the text word
// with last set ends the job. Output channel (o_out_valid / i_out_stall /
// o_out_word) carries one word per job: found, start, length, overflow.
// Steps: a pattern word or a text word that leaves the window as it is
// is accepted, then its need count is written back after the synchronous
// RAM read. Every left-edge shrink step adds a text RAM read, a need RAM
// read and a need write-back. Shrink steps total at most the text length
// per job. The word with last adds a step to load the result into the
// output register, which leaves the pipeline free for the next job's
// words. A new word is stalled until the previous one is done.
// If the previous result is still stalled, the block holds with the new
// result until the output register frees; input is stalled meanwhile.
// Reset clears all control state and the need table's valid bits at once;
// no clearing pass is needed, and the block accepts words right after it.
// Uses mwc_pkg, mwc_seq, mwc_need_ram, mwc_text_ram and assert_macros.svh.
`include "assert_macros.svh"

module min_window_cover_finder #(
    parameter int unsigned TEXT_DEPTH = 4096,
    parameter int unsigned ALPHABET   = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mwc_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mwc_pkg::t_out_word o_out_word
);
    localparam int unsigned AW = $clog2(ALPHABET);
    localparam int unsigned TW = $clog2(TEXT_DEPTH);
    localparam int unsigned CW = $clog2(TEXT_DEPTH) + 2;

    mwc_pkg::t_res      w_res;
    mwc_pkg::t_need_ctl w_need_ctl;
    mwc_pkg::t_text_ctl w_text_ctl;
    logic [AW-1:0]      w_need_rd_addr;
    logic [AW-1:0]      w_need_wr_addr;
    logic [CW-1:0]      w_need_wr_data;
    logic [CW-1:0]      w_need_rd_data;
    logic [TW-1:0]      w_text_rd_addr;
    logic [TW-1:0]      w_text_wr_addr;
    logic [AW-1:0]      w_text_wr_data;
    logic [AW-1:0]      w_text_rd_data;
    logic               w_slot_free;

    logic               r_out_valid;
    mwc_pkg::t_out_word r_out_word;

    mwc_seq #(
        .TEXT_DEPTH(TEXT_DEPTH),
        .ALPHABET  (ALPHABET)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_word     (i_in_word),
        .i_slot_free   (w_slot_free),
        .o_res         (w_res),
        .o_need_ctl    (w_need_ctl),
        .o_need_rd_addr(w_need_rd_addr),
        .o_need_wr_addr(w_need_wr_addr),
        .o_need_wr_data(w_need_wr_data),
        .i_need_rd_data(w_need_rd_data),
        .o_text_ctl    (w_text_ctl),
        .o_text_rd_addr(w_text_rd_addr),
        .o_text_wr_addr(w_text_wr_addr),
        .o_text_wr_data(w_text_wr_data),
        .i_text_rd_data(w_text_rd_data)
    );

    mwc_need_ram #(
        .ALPHABET(ALPHABET),
        .CW      (CW)
    ) u_need_ram (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_need_ctl),
        .i_rd_addr(w_need_rd_addr),
        .i_wr_addr(w_need_wr_addr),
        .i_wr_data(w_need_wr_data),
        .o_rd_data(w_need_rd_data)
    );

    mwc_text_ram #(
        .TEXT_DEPTH(TEXT_DEPTH),
        .DW        (AW)
    ) u_text_ram (
        .i_clk    (i_clk),
        .i_ctl    (w_text_ctl),
        .i_rd_addr(w_text_rd_addr),
        .i_wr_addr(w_text_wr_addr),
        .i_wr_data(w_text_wr_data),
        .o_rd_data(w_text_rd_data)
    );

    // The output register can take a new word when empty or being drained.
    assign w_slot_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.load) begin
            r_out_word <= w_res.word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `ASSERT_IMPL(a_load_when_free, i_clk, i_rst_n, w_res.load, !r_out_valid || !i_out_stall, "result loaded over a stalled word")
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input not stalled while a word is in work")
    `ASSERT_NEXT(a_idle_after_result, i_clk, i_rst_n, w_res.load, !o_in_stall && !w_need_ctl.clr, "sequencer not idle after a result")

endmodule
